// ===== sv/egs_pkg.sv =====
`default_nettype none

package egs_pkg;

	// fixed field widths
	localparam int PIX_W  = 8;
	localparam int CFG_W  = 11;
	localparam int GRAD_W = 11;   // signed gradient, holds +-1020
	localparam int SUM_W  = 11;   // |a| + |b|, at most 2040

	localparam logic [PIX_W-1:0] PIX_MAX          = 8'd255;
	localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 11'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

	// register indexes
	typedef logic [1:0] egs_reg_idx_t;
	localparam egs_reg_idx_t REG_MODE         = 2'd0;
	localparam egs_reg_idx_t REG_LINE_WIDTH   = 2'd1;
	localparam egs_reg_idx_t REG_FRAME_HEIGHT = 2'd2;

	typedef enum logic [1:0] {
		MODE_SOBEL,
		MODE_PREWITT,
		MODE_ROBERTS,
		MODE_LAPLACE
	} egs_mode_t;

	// frame geometry as seen by the front, with a restart pulse on a size write
	typedef struct packed {
		logic [CFG_W-1:0] line_width;
		logic [CFG_W-1:0] frame_height;
		logic             restart;
	} egs_size_t;

	// one window step issued by the front
	typedef struct packed {
		logic             is_pixel;   // bottom row from input, line buffers updated
		logic             top_dup;    // first image row: top row copies the middle
		logic             eval;       // a centre completes on this step
		logic             left_dup;   // left column replicated from the middle one
		logic             right_dup;  // right column replicated from the middle one
		logic             last;       // result closes the frame
		logic [PIX_W-1:0] pixel;
	} egs_cmd_t;

	// one window column, top to bottom
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} egs_col_t;

endpackage

`default_nettype wire

// ===== sv/egs_ifs.sv =====
`default_nettype none

// pixel stream
interface egs_pix_if;
	logic                      valid;
	logic                      ready;
	logic [egs_pkg::PIX_W-1:0] pixel;
	logic                      flush;

	modport source (output valid, output pixel, output flush, input ready);
	modport sink (input valid, input pixel, input flush, output ready);
endinterface

// edge result stream
interface egs_res_if;
	logic                      valid;
	logic                      ready;
	logic [egs_pkg::PIX_W-1:0] edge_value;
	logic                      frame_last;

	modport source (output valid, output edge_value, output frame_last, input ready);
	modport sink (input valid, input edge_value, input frame_last, output ready);
endinterface

`default_nettype wire

// ===== sv/egs_front.sv =====
`default_nettype none

module egs_front #(
	parameter int MAX_LINE_WIDTH   = 1024,
	parameter int MAX_FRAME_HEIGHT = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	egs_pix_if.sink                                  pixels,
	input  wire egs_pkg::egs_size_t                  size,
	output logic                                     push,
	output egs_pkg::egs_cmd_t                        push_cmd,
	output logic [$clog2(MAX_LINE_WIDTH)-1:0]        push_addr,
	input  wire logic                                push_ready
);

	localparam int CW = $clog2(MAX_LINE_WIDTH);
	localparam int RW = $clog2(MAX_FRAME_HEIGHT + 2);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          drain_q;   // frame fully received, owed results go out

	logic [CW-1:0] wm1;
	logic [RW-1:0] hm1;
	logic          w_one;
	logic          col_first, col_second, row_one, row_ge1, row_ge2;
	logic          hit_here, row_end, frame_end_row, final_pos;
	logic          internal, take, drop;

	// effective sizes, clamped to 1..max
	always_comb begin
		if (size.line_width == '0) begin
			wm1 = '0;
		end else if (32'(size.line_width) > 32'(MAX_LINE_WIDTH)) begin
			wm1 = CW'(MAX_LINE_WIDTH - 1);
		end else begin
			wm1 = CW'(size.line_width - 1'b1);
		end
		if (size.frame_height == '0) begin
			hm1 = '0;
		end else if (32'(size.frame_height) > 32'(MAX_FRAME_HEIGHT)) begin
			hm1 = RW'(MAX_FRAME_HEIGHT - 1);
		end else begin
			hm1 = RW'(size.frame_height - 1'b1);
		end
	end

	// raster position decode
	assign w_one         = (wm1 == '0);
	assign col_first     = (col_q == '0);
	assign col_second    = (col_q == CW'(1));
	assign row_one       = (row_q == RW'(1));
	assign row_ge1       = (row_q != '0);
	assign row_ge2       = (row_q > RW'(1));
	assign hit_here      = col_first ? row_ge2 : row_ge1;
	assign row_end       = (col_q == wm1);
	assign frame_end_row = (row_q == hm1);
	assign final_pos     = (row_q == hm1 + RW'(2));

	// a drain step that completes no centre runs without taking an item
	assign internal     = drain_q && !hit_here;
	assign pixels.ready = push_ready && !internal;
	assign take         = pixels.valid && pixels.ready;
	assign drop         = take && !drain_q && pixels.flush;
	assign push         = (take && !drop) || (internal && push_ready);

	// step command
	always_comb begin
		push_cmd.is_pixel  = !drain_q;
		push_cmd.top_dup   = row_one;
		push_cmd.eval      = hit_here;
		push_cmd.left_dup  = col_first ? w_one : col_second;
		push_cmd.right_dup = col_first;
		push_cmd.last      = drain_q && final_pos;
		push_cmd.pixel     = pixels.pixel;
	end
	assign push_addr = col_q;

	// position and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= 1'b0;
		end else if (size.restart) begin
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= 1'b0;
		end else if (push) begin
			if (drain_q && final_pos) begin
				col_q   <= '0;
				row_q   <= '0;
				drain_q <= 1'b0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
				if (!drain_q && frame_end_row) begin
					drain_q <= 1'b1;
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/egs_cmd_fifo.sv =====
`default_nettype none

module egs_cmd_fifo #(
	parameter int DW = 24
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [DW-1:0] push_data,
	output logic               push_ready,
	input  wire logic          pop,
	output logic [DW-1:0]      pop_data,
	output logic               pop_valid
);

	logic [DW-1:0] slot_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_push, do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/egs_back.sv =====
`default_nettype none

module egs_back #(
	parameter int MAX_LINE_WIDTH = 1024
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire egs_pkg::egs_mode_t             mode,
	input  wire logic                           cmd_valid,
	input  wire egs_pkg::egs_cmd_t              cmd,
	input  wire logic [$clog2(MAX_LINE_WIDTH)-1:0] cmd_addr,
	output logic                                cmd_pop,
	egs_res_if.source                           results
);

	localparam int AW = $clog2(MAX_LINE_WIDTH);
	localparam int PW = egs_pkg::PIX_W;
	localparam int GW = egs_pkg::GRAD_W;
	localparam int SW = egs_pkg::SUM_W;

	// line buffers: {row two above, row above} per column
	logic [2*PW-1:0] lb_mem [MAX_LINE_WIDTH];
	logic [2*PW-1:0] lb_rd_q;
	logic [2*PW-1:0] lb_wdata;
	logic            lb_we;

	logic                adv;
	logic                valid_s1;
	egs_pkg::egs_cmd_t   cmd_s1;
	logic [AW-1:0]       addr_s1;
	logic                fwd_s1;
	logic [2*PW-1:0]     fwd_data_s1;
	logic [2*PW-1:0]     rd_s1;
	egs_pkg::egs_col_t   col_s1;

	egs_pkg::egs_col_t   win_q [3];

	logic                hit_s2, left_dup_s2, right_dup_s2, last_s2;
	egs_pkg::egs_col_t   lc, mc, rc;
	logic signed [GW-1:0] sob_gx, sob_gy, pre_gx, pre_gy, rob_a, rob_b, lap_v;
	logic signed [GW-1:0] grad_a, grad_b;
	logic                halve;

	logic                hit_s3, last_s3, halve_s3;
	logic signed [GW-1:0] grad_a_s3, grad_b_s3;
	logic [SW-1:0]       sum_s3, val_s3;
	logic [PW-1:0]       sat_s3;

	logic                out_valid_q, frame_last_q;
	logic [PW-1:0]       edge_value_q;

	function automatic logic signed [GW-1:0] sx(input logic [PW-1:0] v);
		return $signed(GW'(v));
	endfunction

	function automatic logic [SW-1:0] mag(input logic signed [GW-1:0] v);
		logic signed [GW-1:0] n;
		n = v[GW-1] ? -v : v;
		return SW'($unsigned(n));
	endfunction

	// whole pipeline moves when the output register can take a result
	assign adv     = !out_valid_q || results.ready;
	assign cmd_pop = adv && cmd_valid;

	// line buffer read on pop, write as the step leaves stage 1
	assign lb_we = adv && valid_s1 && cmd_s1.is_pixel;
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			lb_rd_q <= lb_mem[cmd_addr];
		end
		if (lb_we) begin
			lb_mem[addr_s1] <= lb_wdata;
		end
	end

	// stage 1 payload, with bypass when the read hit the column being written
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_s1      <= cmd;
			addr_s1     <= cmd_addr;
			fwd_s1      <= lb_we && (cmd_addr == addr_s1);
			fwd_data_s1 <= lb_wdata;
		end
	end

	// column assembly with top and bottom replication
	always_comb begin
		rd_s1      = fwd_s1 ? fwd_data_s1 : lb_rd_q;
		col_s1.mid = rd_s1[PW-1:0];
		col_s1.top = cmd_s1.top_dup ? rd_s1[PW-1:0] : rd_s1[2*PW-1:PW];
		col_s1.bot = cmd_s1.is_pixel ? cmd_s1.pixel : rd_s1[PW-1:0];
		lb_wdata   = {rd_s1[PW-1:0], cmd_s1.pixel};
	end

	// 3x3 window shift
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= col_s1;
		end
	end

	// stage 2 flags
	always_ff @(posedge clk) begin
		if (adv) begin
			left_dup_s2  <= cmd_s1.left_dup;
			right_dup_s2 <= cmd_s1.right_dup;
			last_s2      <= cmd_s1.last;
		end
	end

	// gradients on the loaded window, left and right replicated at row ends
	always_comb begin
		lc = left_dup_s2 ? win_q[1] : win_q[0];
		mc = win_q[1];
		rc = right_dup_s2 ? win_q[1] : win_q[2];

		sob_gx = sx(rc.top) + (sx(rc.mid) <<< 1) + sx(rc.bot)
			- sx(lc.top) - (sx(lc.mid) <<< 1) - sx(lc.bot);
		sob_gy = sx(lc.bot) + (sx(mc.bot) <<< 1) + sx(rc.bot)
			- sx(lc.top) - (sx(mc.top) <<< 1) - sx(rc.top);
		pre_gx = sx(rc.top) + sx(rc.mid) + sx(rc.bot)
			- sx(lc.top) - sx(lc.mid) - sx(lc.bot);
		pre_gy = sx(lc.bot) + sx(mc.bot) + sx(rc.bot)
			- sx(lc.top) - sx(mc.top) - sx(rc.top);
		rob_a  = sx(rc.bot) - sx(mc.mid);
		rob_b  = sx(mc.bot) - sx(rc.mid);
		lap_v  = sx(mc.top) + sx(lc.mid) + sx(rc.mid) + sx(mc.bot) - (sx(mc.mid) <<< 2);

		case (mode)
			egs_pkg::MODE_SOBEL: begin
				grad_a = sob_gx;
				grad_b = sob_gy;
				halve  = 1'b1;
			end
			egs_pkg::MODE_PREWITT: begin
				grad_a = pre_gx;
				grad_b = pre_gy;
				halve  = 1'b1;
			end
			egs_pkg::MODE_ROBERTS: begin
				grad_a = rob_a;
				grad_b = rob_b;
				halve  = 1'b1;
			end
			default: begin
				grad_a = lap_v;
				grad_b = '0;
				halve  = 1'b0;
			end
		endcase
	end

	// stage 3 payload
	always_ff @(posedge clk) begin
		if (adv) begin
			grad_a_s3 <= grad_a;
			grad_b_s3 <= grad_b;
			halve_s3  <= halve;
			last_s3   <= last_s2;
		end
	end

	// magnitude, halving and saturation
	always_comb begin
		sum_s3 = mag(grad_a_s3) + mag(grad_b_s3);
		val_s3 = halve_s3 ? {1'b0, sum_s3[SW-1:1]} : sum_s3;
		sat_s3 = (val_s3 > SW'(egs_pkg::PIX_MAX)) ? egs_pkg::PIX_MAX : val_s3[PW-1:0];
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			hit_s2      <= 1'b0;
			hit_s3      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= cmd_valid;
			hit_s2      <= valid_s1 && cmd_s1.eval;
			hit_s3      <= hit_s2;
			out_valid_q <= hit_s3;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			edge_value_q <= sat_s3;
			frame_last_q <= last_s3;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.edge_value = edge_value_q;
	assign results.frame_last = frame_last_q;

endmodule

`default_nettype wire

// ===== sv/edge_gradient_3x3_stream.sv =====
`default_nettype none

// Channel   Dir  Handshake      Payload
// pixels    in   valid/ready    pixel[7:0], flush
// results   out  valid/ready    edge_value[7:0], frame_last
// cfg       in   cfg_we         cfg_index[1:0], cfg_data[10:0]
//
// One item per clock while nothing stalls and no drain step runs, set by the
// single-step front and one line buffer read plus one write per pixel on two ports.
// The item that completes a window travels the step queue, stage 1, stage 2,
// stage 3 and the output register before its result leaves.
// Reset clears control and configuration; the line buffers are not cleared.
// The output register and a two-entry step queue let either side stall alone.

module edge_gradient_3x3_stream #(
	parameter int MAX_LINE_WIDTH   = 1024,
	parameter int MAX_FRAME_HEIGHT = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	egs_pix_if.sink                            pixels,
	egs_res_if.source                          results,
	input  wire logic                          cfg_we,
	input  wire egs_pkg::egs_reg_idx_t         cfg_index,
	input  wire logic [egs_pkg::CFG_W-1:0]     cfg_data
);

	localparam int AW = $clog2(MAX_LINE_WIDTH);
	localparam int QW = AW + $bits(egs_pkg::egs_cmd_t);

	egs_pkg::egs_mode_t           mode_q;
	logic [egs_pkg::CFG_W-1:0]    line_width_q;
	logic [egs_pkg::CFG_W-1:0]    frame_height_q;
	logic                         size_write;
	egs_pkg::egs_size_t           size;

	egs_pkg::egs_cmd_t            fr_cmd, q_cmd;
	logic [AW-1:0]                fr_addr, q_addr;
	logic                         fr_push, q_ready, q_valid, bk_pop;
	logic [QW-1:0]                q_word;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= egs_pkg::MODE_SOBEL;
			line_width_q   <= egs_pkg::LINE_WIDTH_RST;
			frame_height_q <= egs_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				egs_pkg::REG_MODE:         mode_q         <= egs_pkg::egs_mode_t'(cfg_data[1:0]);
				egs_pkg::REG_LINE_WIDTH:   line_width_q   <= cfg_data;
				egs_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a size write restarts the frame
	assign size_write = cfg_we && (cfg_index == egs_pkg::REG_LINE_WIDTH ||
		cfg_index == egs_pkg::REG_FRAME_HEIGHT);
	assign size.line_width   = line_width_q;
	assign size.frame_height = frame_height_q;
	assign size.restart      = size_write;

	egs_front #(
		.MAX_LINE_WIDTH   (MAX_LINE_WIDTH),
		.MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixels     (pixels),
		.size       (size),
		.push       (fr_push),
		.push_cmd   (fr_cmd),
		.push_addr  (fr_addr),
		.push_ready (q_ready)
	);

	egs_cmd_fifo #(
		.DW (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fr_push),
		.push_data  ({fr_addr, fr_cmd}),
		.push_ready (q_ready),
		.pop        (bk_pop),
		.pop_data   (q_word),
		.pop_valid  (q_valid)
	);

	assign {q_addr, q_cmd} = q_word;

	egs_back #(
		.MAX_LINE_WIDTH (MAX_LINE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.cmd_addr  (q_addr),
		.cmd_pop   (bk_pop),
		.results   (results)
	);

endmodule

`default_nettype wire

// ===== sv/egs_checker.sv =====
`default_nettype none

module egs_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] edge_value,
	input wire logic       frame_last
);

	logic        in_xfer, out_xfer;
	logic [31:0] credit_q;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// items taken minus results given, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (in_xfer && !out_xfer && credit_q != '1) begin
			credit_q <= credit_q + 32'd1;
		end else if (!in_xfer && out_xfer && credit_q != '0 && credit_q != '1) begin
			credit_q <= credit_q - 32'd1;
		end
	end

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(edge_value) && $stable(frame_last))
		else $error("result payload changed while stalled");

	// every result transfer is backed by an earlier item transfer
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> credit_q != '0)
		else $error("more results than items");

	// with the output idle, the input is not held blocked across consecutive cycles
	a_in_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && $past(!out_valid) |-> in_ready || $past(in_ready))
		else $error("input blocked while output idle");

endmodule

bind edge_gradient_3x3_stream egs_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (pixels.valid),
	.in_ready   (pixels.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.edge_value (results.edge_value),
	.frame_last (results.frame_last)
);

`default_nettype wire

// ===== test/edge_gradient_checker.sv =====
`timescale 1ns / 1ps

// Watches the pixel, result and register channels, predicts every edge value
// and compares it with what the block delivers.
module edge_gradient_checker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	egs_pix_if                                pix,
	egs_res_if                                res,
	input  wire logic                         cfg_we,
	input  wire egs_pkg::egs_reg_idx_t        cfg_index,
	input  wire logic [egs_pkg::CFG_W-1:0]    cfg_data,
	output int                                fail_count,
	output int                                owed_results
);

	localparam int PIX_W    = egs_pkg::PIX_W;
	localparam int CFG_W    = egs_pkg::CFG_W;
	localparam int LINE_MAX = 1024;
	localparam int ROWS_MAX = 1024;

	typedef struct packed {
		logic [PIX_W-1:0] edge_value;
		logic             frame_last;
	} edge_res_t;

	// predictor state
	egs_pkg::egs_mode_t cur_mode;
	logic [CFG_W-1:0]   width_reg;
	logic [CFG_W-1:0]   height_reg;
	logic [PIX_W-1:0]   line_up [LINE_MAX];
	logic [PIX_W-1:0]   line_up2 [LINE_MAX];
	logic [PIX_W-1:0]   win [9];
	int                 col_pos;
	int                 row_pos;
	int                 flush_owed;
	edge_res_t          expected_edges [$];

	function automatic int clamp_dim(logic [CFG_W-1:0] v, int hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return int'(v);
	endfunction

	function automatic int mag(int v);
		return (v < 0) ? -v : v;
	endfunction

	// window columns: 0 oldest, 2 newest; row 0 on top
	function automatic logic [PIX_W-1:0] window_edge(int lc, int mc, int rc);
		int p [3][3];
		int gx, gy, v;
		for (int r = 0; r < 3; r++) begin
			p[r][0] = win[lc*3 + r];
			p[r][1] = win[mc*3 + r];
			p[r][2] = win[rc*3 + r];
		end
		case (cur_mode)
			egs_pkg::MODE_SOBEL: begin
				gx = p[0][2] + 2*p[1][2] + p[2][2] - p[0][0] - 2*p[1][0] - p[2][0];
				gy = p[2][0] + 2*p[2][1] + p[2][2] - p[0][0] - 2*p[0][1] - p[0][2];
				v = (mag(gx) + mag(gy)) / 2;
			end
			egs_pkg::MODE_PREWITT: begin
				gx = p[0][2] + p[1][2] + p[2][2] - p[0][0] - p[1][0] - p[2][0];
				gy = p[2][0] + p[2][1] + p[2][2] - p[0][0] - p[0][1] - p[0][2];
				v = (mag(gx) + mag(gy)) / 2;
			end
			egs_pkg::MODE_ROBERTS: begin
				v = (mag(p[2][2] - p[1][1]) + mag(p[2][1] - p[1][2])) / 2;
			end
			default: begin
				// Laplacian
				v = mag(p[0][1] + p[1][0] + p[1][2] + p[2][1] - 4*p[1][1]);
			end
		endcase
		return (v > 255) ? egs_pkg::PIX_MAX : v[PIX_W-1:0];
	endfunction

	function automatic void shift_column(logic [PIX_W-1:0] top, logic [PIX_W-1:0] mid,
			logic [PIX_W-1:0] bot);
		for (int i = 0; i < 6; i++)
			win[i] = win[i+3];
		win[6] = top;
		win[7] = mid;
		win[8] = bot;
	endfunction

	// one raster position; returns 1 when a centre completes
	function automatic bit visit_column(int r, int c, bit is_pix, logic [PIX_W-1:0] px,
			int w, output logic [PIX_W-1:0] val);
		int               ci;
		logic [PIX_W-1:0] mid, top, bot;
		bit               hit;
		val = '0;
		hit = 1'b0;
		ci = (c < LINE_MAX) ? c : LINE_MAX - 1;
		mid = line_up[ci];
		top = (r == 1) ? mid : line_up2[ci];
		bot = is_pix ? px : mid;
		if (c == 0) begin
			// left column replicated when the row is one pixel wide
			if (r >= 2) begin
				val = window_edge((w >= 2) ? 1 : 2, 2, 2);
				hit = 1'b1;
			end
			shift_column(top, mid, bot);
		end else begin
			shift_column(top, mid, bot);
			if (r >= 1) begin
				val = window_edge((c == 1) ? 1 : 0, 1, 2);
				hit = 1'b1;
			end
		end
		if (is_pix) begin
			line_up2[ci] = line_up[ci];
			line_up[ci] = px;
		end
		return hit;
	endfunction

	function automatic void predict_edge(logic [PIX_W-1:0] px, logic fl);
		int               w, h;
		logic [PIX_W-1:0] val;
		bit               hit, last;
		w = clamp_dim(width_reg, LINE_MAX);
		h = clamp_dim(height_reg, ROWS_MAX);
		hit = 1'b0;
		last = 1'b0;
		val = '0;
		if (flush_owed == 0) begin
			// flush inside a frame does nothing
			if (fl)
				return;
			hit = visit_column(row_pos, col_pos, 1'b1, px, w, val);
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= h)
					flush_owed = (h >= 2) ? w + 1 : w;
			end
		end else begin
			// draining: a pixel here counts as a flush and is dropped
			while (!hit) begin
				hit = visit_column(row_pos, col_pos, 1'b0, '0, w, val);
				if (row_pos > h) begin
					last = 1'b1;
					break;
				end
				col_pos++;
				if (col_pos >= w) begin
					col_pos = 0;
					row_pos = h + 1;
				end
			end
			flush_owed--;
			if (last) begin
				col_pos = 0;
				row_pos = 0;
				flush_owed = 0;
			end
		end
		if (hit)
			expected_edges.push_back('{edge_value: val, frame_last: last});
	endfunction

	function automatic void apply_write(egs_pkg::egs_reg_idx_t idx, logic [CFG_W-1:0] data);
		case (idx)
			egs_pkg::REG_MODE: cur_mode = egs_pkg::egs_mode_t'(data[1:0]);
			egs_pkg::REG_LINE_WIDTH, egs_pkg::REG_FRAME_HEIGHT: begin
				// a size write drops the frame in progress
				if (idx == egs_pkg::REG_LINE_WIDTH)
					width_reg = data;
				else
					height_reg = data;
				col_pos = 0;
				row_pos = 0;
				flush_owed = 0;
			end
			default: ;
		endcase
	endfunction

	// compare first, then take this edge's register write and pixel transfer
	always @(posedge clk or negedge arst_n) begin
		edge_res_t want;
		if (!arst_n) begin
			cur_mode = egs_pkg::MODE_SOBEL;
			width_reg = egs_pkg::LINE_WIDTH_RST;
			height_reg = egs_pkg::FRAME_HEIGHT_RST;
			for (int i = 0; i < LINE_MAX; i++) begin
				line_up[i] = '0;
				line_up2[i] = '0;
			end
			for (int i = 0; i < 9; i++)
				win[i] = '0;
			col_pos = 0;
			row_pos = 0;
			flush_owed = 0;
			expected_edges.delete();
			fail_count = 0;
			owed_results = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_edges.size() == 0) begin
					$error("unexpected result: edge_value %0d frame_last %0d",
						res.edge_value, res.frame_last);
					fail_count++;
				end else begin
					want = expected_edges.pop_front();
					if (res.edge_value !== want.edge_value) begin
						$error("edge_value: expected %0d, got %0d",
							want.edge_value, res.edge_value);
						fail_count++;
					end
					if (res.frame_last !== want.frame_last) begin
						$error("frame_last: expected %0d, got %0d",
							want.frame_last, res.frame_last);
						fail_count++;
					end
				end
			end
			if (cfg_we)
				apply_write(cfg_index, cfg_data);
			if (pix.valid && pix.ready)
				predict_edge(pix.pixel, pix.flush);
			owed_results = expected_edges.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int PIX_W = egs_pkg::PIX_W;
	localparam int CFG_W = egs_pkg::CFG_W;
	localparam egs_pkg::egs_reg_idx_t REG_SPARE = 2'd3;   // no register behind this index
	localparam int DIM_MAX       = 1024;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_ITEMS  = 300;
	localparam int DRAIN_LIMIT   = 20000;

	typedef enum int {
		PAT_NOISE,
		PAT_BINARY,
		PAT_CHECKER,
		PAT_FLAT,
		PAT_RAMP
	} pattern_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	egs_pkg::egs_reg_idx_t cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	int                    fail_count;
	int                    owed_results;
	bit                    steady;        // no idling on either side while set
	int                    ready_hold;
	int                    frame_items;
	int                    cur_w;
	int                    cur_h;

	egs_pix_if pix();
	egs_res_if res();

	edge_gradient_3x3_stream dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pix),
		.results   (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	edge_gradient_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix          (pix),
		.res          (res),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.owed_results (owed_results)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("[edge_gradient_3x3_stream] ERROR");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// result side backpressure
	initial begin
		res.ready = 1'b0;
		ready_hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (ready_hold > 0) begin
				res.ready <= 1'b0;
				ready_hold--;
			end else begin
				res.ready <= 1'b1;
				if (!steady && $urandom_range(0, 99) < 20)
					ready_hold = gap_len();
			end
		end
	end

	function automatic int frame_dim(logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > DIM_MAX)
			return DIM_MAX;
		return int'(v);
	endfunction

	function automatic int small_dim(int hi);
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return 0;
		if (r < 12)
			return $urandom_range(hi + 1, 4 * hi);
		return $urandom_range(1, hi);
	endfunction

	function automatic logic [PIX_W-1:0] frame_pixel(pattern_t kind, int base, int r, int c);
		int v;
		case (kind)
			PAT_BINARY:  return $urandom_range(0, 1) ? egs_pkg::PIX_MAX : 8'h00;
			PAT_CHECKER: return ((r + c) % 2) ? egs_pkg::PIX_MAX : 8'h00;
			PAT_FLAT: begin
				v = base + int'($urandom_range(0, 8)) - 4;
				if (v < 0)
					v = 0;
				if (v > 255)
					v = 255;
				return v[PIX_W-1:0];
			end
			PAT_RAMP:    return 8'((c * 37) + (r * 11) + base);
			default:     return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// one transfer on the pixel channel; called and returns at a falling edge
	task automatic send(input logic [PIX_W-1:0] px, input logic fl);
		int gap;
		gap = (!steady && $urandom_range(0, 99) < 25) ? gap_len() : 0;
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix.valid <= 1'b1;
		pix.pixel <= px;
		pix.flush <= fl;
		@(posedge clk);
		while (!pix.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// hold off until every result is in and the pipe has drained
	task automatic settle();
		pix.valid <= 1'b0;
		while (owed_results != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input egs_pkg::egs_reg_idx_t idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_size(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv);
		write_reg(egs_pkg::REG_LINE_WIDTH, wv);
		write_reg(egs_pkg::REG_FRAME_HEIGHT, hv);
		cur_w = frame_dim(wv);
		cur_h = frame_dim(hv);
	endtask

	// full frame plus its drain; with noise it also throws in stray flushes,
	// pixels during the drain, mid-frame mode changes and dropped frames
	task automatic run_frame(input pattern_t kind, input bit noisy);
		int base;
		int drain;
		base = $urandom_range(0, 255);
		for (int r = 0; r < cur_h; r++) begin
			for (int c = 0; c < cur_w; c++) begin
				if (noisy && $urandom_range(0, 99) < 3)
					send(8'($urandom_range(0, 255)), 1'b1);
				if (noisy && $urandom_range(0, 999) < 3)
					settle();
				if (noisy && $urandom_range(0, 999) < 3) begin
					settle();
					write_reg(egs_pkg::REG_MODE, CFG_W'($urandom()));
				end
				if (noisy && $urandom_range(0, 1999) < 2) begin
					settle();
					set_size(CFG_W'(small_dim(12)), CFG_W'(small_dim(6)));
					return;
				end
				send(frame_pixel(kind, base, r, c), 1'b0);
				frame_items++;
			end
		end
		drain = (cur_h >= 2) ? cur_w + 1 : cur_w;
		for (int k = 0; k < drain; k++) begin
			send(8'($urandom_range(0, 255)),
				(noisy && $urandom_range(0, 99) < 10) ? 1'b0 : 1'b1);
			frame_items++;
		end
		if (noisy && $urandom_range(0, 99) < 20)
			send(8'($urandom_range(0, 255)), 1'b1);
	endtask

	initial begin
		egs_pkg::egs_mode_t dir_modes [3];
		int                 waited;
		dir_modes = '{egs_pkg::MODE_PREWITT, egs_pkg::MODE_ROBERTS, egs_pkg::MODE_LAPLACE};
		waited = 0;
		frame_items = 0;
		steady = 1'b0;
		cur_w = frame_dim(egs_pkg::LINE_WIDTH_RST);
		cur_h = frame_dim(egs_pkg::FRAME_HEIGHT_RST);
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = egs_pkg::REG_MODE;
		cfg_data = '0;
		pix.valid = 1'b0;
		pix.pixel = '0;
		pix.flush = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		settle();

		// directed: unused index, checkerboard in Sobel with a flush inside the
		// frame, a pixel during the drain and a flush after the frame
		write_reg(REG_SPARE, '1);
		write_reg(egs_pkg::REG_MODE, CFG_W'(egs_pkg::MODE_SOBEL));
		set_size(11'd3, 11'd2);
		for (int i = 0; i < 6; i++) begin
			send((i % 2) ? egs_pkg::PIX_MAX : 8'h00, 1'b0);
			if (i == 2)
				send(8'h5A, 1'b1);
		end
		send(8'hA5, 1'b0);
		repeat (3) send(8'h00, 1'b1);
		send(8'h00, 1'b1);

		// remaining operators on a two-pixel row
		settle();
		set_size(11'd2, 11'd1);
		foreach (dir_modes[i]) begin
			settle();
			write_reg(egs_pkg::REG_MODE, CFG_W'(dir_modes[i]));
			send(egs_pkg::PIX_MAX, 1'b0);
			send(8'h00, 1'b0);
			send(8'hFF, 1'b1);
			send(8'h00, 1'b1);
		end

		// single pixel frame
		settle();
		set_size(11'd1, 11'd1);
		send(egs_pkg::PIX_MAX, 1'b0);
		send(8'h00, 1'b1);

		// random frames, mostly small
		frame_items = 0;
		while (frame_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 35) begin
				settle();
				if ($urandom_range(0, 99) < 50)
					write_reg(egs_pkg::REG_MODE, CFG_W'($urandom()));
				set_size(CFG_W'(small_dim(12)), CFG_W'(small_dim(6)));
			end
			steady = ($urandom_range(0, 99) < 15);
			run_frame(pattern_t'($urandom_range(0, 4)), 1'b1);
		end
		steady = 1'b0;

		// tallest column, at or past the clamp
		settle();
		write_reg(egs_pkg::REG_MODE, CFG_W'($urandom()));
		set_size(11'd1, $urandom_range(0, 1) ? 11'd1024 : CFG_W'($urandom_range(1025, 2047)));
		run_frame(PAT_NOISE, 1'b0);

		// drain and verdict
		pix.valid <= 1'b0;
		while (owed_results != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && owed_results == 0)
			$display("[edge_gradient_3x3_stream] OK");
		else
			$display("[edge_gradient_3x3_stream] ERROR");
		$finish;
	end

endmodule
